/* hw/rtl/fpda_pkg.sv */
// Shared types and constants of the fixed-point to decimal ASCII formatter.
`default_nettype none

package fpda_pkg;

  // Input field widths and integer digit capacity
  localparam int INT_BITS        = 31;
  localparam int FRAC_IN_BITS    = 16;
  localparam int INT_DIGITS      = 10;
  localparam int DIGIT_W         = 4;
  localparam int CHAR_W          = 8;

  // Register field widths and limits
  localparam int MIN_WIDTH_BITS  = 5;
  localparam int FRAC_DIG_BITS   = 3;
  localparam int FRAC_DIGITS_MAX = 4;

  // Parameter defaults
  localparam int MAX_MIN_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF     = 16;

  // Configuration bus
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_MIN_WIDTH     = 2'd0;
  localparam logic [1:0] REG_PAD_WITH_ZERO = 2'd1;
  localparam logic [1:0] REG_FRAC_DIGITS   = 2'd2;

  // Characters
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;

  typedef struct packed {
    logic [MIN_WIDTH_BITS-1:0] min_width;
    logic                      pad_with_zero;
    logic [FRAC_DIG_BITS-1:0]  frac_digits;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_LOAD    = 3'd1,
    OP_SHIFT   = 3'd2,
    OP_MEASURE = 3'd3,
    OP_PAD     = 3'd4,
    OP_INT     = 3'd5,
    OP_POINT   = 3'd6,
    OP_FRAC    = 3'd7
  } op_t;

  typedef struct packed {
    logic conv_done;
    logic pad_zero;
    logic int_one;
    logic has_frac;
    logic frac_one;
  } status_t;

endpackage

`default_nettype wire

/* hw/rtl/fpda_regs.sv */
// Configuration register file behind the APB-style port.
`default_nettype none

module fpda_regs
  import fpda_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MIN_WIDTH:     cfg.min_width     <= pwdata[MIN_WIDTH_BITS-1:0];
        REG_PAD_WITH_ZERO: cfg.pad_with_zero <= pwdata[0];
        REG_FRAC_DIGITS:   cfg.frac_digits   <= pwdata[FRAC_DIG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_MIN_WIDTH:     prdata = DATA_W'(cfg.min_width);
      REG_PAD_WITH_ZERO: prdata = DATA_W'(cfg.pad_with_zero);
      REG_FRAC_DIGITS:   prdata = DATA_W'(cfg.frac_digits);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/fpda_ctrl.sv */
// Sequencing state machine of the formatter.
`default_nettype none

module fpda_ctrl
  import fpda_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  status_t   status,
  output logic      busy,
  output op_t       op
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CONV  = 7'b0000010,
    S_MEAS  = 7'b0000100,
    S_PAD   = 7'b0001000,
    S_INT   = 7'b0010000,
    S_POINT = 7'b0100000,
    S_FRAC  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          op         = OP_LOAD;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        op = OP_SHIFT;
        if (status.conv_done) begin
          state_next = S_MEAS;
        end
      end
      S_MEAS: begin
        op         = OP_MEASURE;
        state_next = S_PAD;
      end
      S_PAD, S_INT: begin
        // pad first, then integer digits; no gap between the two
        if (state == S_PAD && !status.pad_zero) begin
          op = OP_PAD;
        end else begin
          op         = OP_INT;
          state_next = S_INT;
          if (status.int_one) begin
            state_next = status.has_frac ? S_POINT : S_IDLE;
          end
        end
      end
      S_POINT: begin
        op         = OP_POINT;
        state_next = S_FRAC;
      end
      S_FRAC: begin
        op = OP_FRAC;
        if (status.frac_one) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/fpda_dp.sv */
// Datapath: binary to BCD shifter, digit counter, fraction digit generator, output register.
`default_nettype none

module fpda_dp
  import fpda_pkg::*;
#(
  parameter int MAX_MIN_WIDTH = MAX_MIN_WIDTH_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  op_t                          op,
  input  cfg_t                         cfg,
  input  wire logic [INT_BITS-1:0]     int_part,
  input  wire logic [FRAC_IN_BITS-1:0] frac_part,
  output status_t                      status,
  output logic                         valid,
  output logic      [CHAR_W-1:0]       out_char,
  output logic                         last
);

  localparam int WW   = $clog2(MAX_MIN_WIDTH + 1);
  localparam int CMPW = (WW > MIN_WIDTH_BITS) ? WW : MIN_WIDTH_BITS;
  localparam int NDW  = $clog2(INT_DIGITS + 1);
  localparam int PCW  = (WW > NDW) ? WW : NDW;
  localparam int IDXW = $clog2(INT_DIGITS);
  localparam int BCW  = $clog2(INT_BITS);
  localparam int PW   = FRAC_BITS + DIGIT_W;

  logic [INT_BITS-1:0]                sreg;
  logic [INT_DIGITS-1:0][DIGIT_W-1:0] bcd;
  logic [INT_DIGITS-1:0][DIGIT_W-1:0] bcd_adj;
  logic [INT_DIGITS-1:0][DIGIT_W-1:0] bcd_next;
  logic [INT_DIGITS*DIGIT_W-1:0]      bcd_flat;
  logic [BCW-1:0]                     bitcnt;
  logic [WW-1:0]                      width_q;
  logic                               pad_sel;
  logic [FRAC_DIG_BITS-1:0]           fcnt;
  logic [FRAC_DIG_BITS-1:0]           fd_sat;
  logic [FRAC_BITS-1:0]               rem;
  logic [WW-1:0]                      pad_cnt;
  logic [IDXW-1:0]                    idx;
  logic [NDW-1:0]                     nd;
  logic [CMPW-1:0]                    mw_ext;
  logic [CMPW-1:0]                    mw_sat;
  logic [PCW-1:0]                     pad_calc;
  logic [PW-1:0]                      prod;

  // Double dabble: correct each digit, then shift in the next integer bit
  always_comb begin
    for (int i = 0; i < INT_DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= DIGIT_W'(5)) ? bcd[i] + DIGIT_W'(3) : bcd[i];
    end
    bcd_flat = bcd_adj;
    bcd_next = {bcd_flat[INT_DIGITS*DIGIT_W-2:0], sreg[INT_BITS-1]};
  end

  // Significant digit count, at least one
  always_comb begin
    nd = NDW'(1);
    for (int i = 0; i < INT_DIGITS; i++) begin
      if (bcd[i] != '0) begin
        nd = NDW'(i + 1);
      end
    end
    pad_calc = (PCW'(width_q) > PCW'(nd)) ? PCW'(width_q) - PCW'(nd) : '0;
  end

  always_comb begin
    mw_ext = CMPW'(cfg.min_width);
    mw_sat = (mw_ext > CMPW'(MAX_MIN_WIDTH)) ? CMPW'(MAX_MIN_WIDTH) : mw_ext;
    fd_sat = (cfg.frac_digits > FRAC_DIG_BITS'(FRAC_DIGITS_MAX)) ?
             FRAC_DIG_BITS'(FRAC_DIGITS_MAX) : cfg.frac_digits;
    prod   = (PW'(rem) << 3) + (PW'(rem) << 1);
  end

  assign status.conv_done = (bitcnt == BCW'(INT_BITS - 1));
  assign status.pad_zero  = (pad_cnt == '0);
  assign status.int_one   = (idx == '0);
  assign status.has_frac  = (fcnt != '0);
  assign status.frac_one  = (fcnt == FRAC_DIG_BITS'(1));

  // Working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        sreg    <= int_part;
        bcd     <= '0;
        bitcnt  <= '0;
        width_q <= WW'(mw_sat);
        pad_sel <= cfg.pad_with_zero;
        fcnt    <= fd_sat;
        rem     <= FRAC_BITS'(frac_part);
      end
      OP_SHIFT: begin
        sreg   <= {sreg[INT_BITS-2:0], 1'b0};
        bcd    <= bcd_next;
        bitcnt <= bitcnt + BCW'(1);
      end
      OP_MEASURE: begin
        pad_cnt <= WW'(pad_calc);
        idx     <= IDXW'(nd - NDW'(1));
      end
      OP_PAD: begin
        pad_cnt <= pad_cnt - WW'(1);
      end
      OP_INT: begin
        idx <= idx - IDXW'(1);
      end
      OP_FRAC: begin
        rem  <= prod[FRAC_BITS-1:0];
        fcnt <= fcnt - FRAC_DIG_BITS'(1);
      end
      default: ;
    endcase
  end

  // Output register: one character per strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      last  <= 1'b0;
    end else begin
      valid <= (op == OP_PAD) || (op == OP_INT) || (op == OP_POINT) || (op == OP_FRAC);
      last  <= ((op == OP_INT) && (idx == '0) && (fcnt == '0)) ||
               ((op == OP_FRAC) && (fcnt == FRAC_DIG_BITS'(1)));
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_PAD:   out_char <= pad_sel ? CH_ZERO : CH_SPACE;
      OP_INT:   out_char <= CH_ZERO + CHAR_W'(bcd[idx]);
      OP_POINT: out_char <= CH_POINT;
      OP_FRAC:  out_char <= CH_ZERO + CHAR_W'(prod[PW-1:FRAC_BITS]);
      default:  ;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/fixed_point_to_decimal_ascii.sv */
// Top level of the fixed-point to decimal ASCII formatter.
// The first character strobes after the accepting edge, once the BCD converter has run
// its 31 shift-and-correct steps, the digits are counted and the output register loads.
// Each item is N = max(width, digits) characters, plus frac_digits + 1 when a fraction
// is shown, one character per cycle; a new item is taken only when the block is idle.
// Reset clears the register file, state machine and strobe; receiver cannot stall.
`default_nettype none

module fixed_point_to_decimal_ascii
  import fpda_pkg::*;
#(
  parameter int MAX_MIN_WIDTH = MAX_MIN_WIDTH_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // Configuration port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ADDR_W-1:0]       paddr,
  input  wire logic [DATA_W-1:0]       pwdata,
  output logic      [DATA_W-1:0]       prdata,
  output logic                         pready,
  // Command side: a transaction is taken when start is high and busy low
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [INT_BITS-1:0]     int_part,
  input  wire logic [FRAC_IN_BITS-1:0] frac_part,
  // Result side: one character per strobe
  output logic                         valid,
  output logic      [CHAR_W-1:0]       out_char,
  output logic                         last
);

  cfg_t    cfg;
  op_t     op;
  status_t status;

  // Registers are sampled into the datapath when a transaction is taken,
  // so a number is formatted with the settings that stood at its start.
  fpda_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: convert, count digits, then walk pad, integer digits,
  // point and fraction digits when a fraction is shown, issuing one emit command per cycle.
  fpda_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .op     (op)
  );

  // Datapath: the integer goes through a bit-serial BCD converter; fraction
  // digits come out one by one from a times-ten step on the remainder.
  fpda_dp #(
    .MAX_MIN_WIDTH (MAX_MIN_WIDTH),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .cfg       (cfg),
    .int_part  (int_part),
    .frac_part (frac_part),
    .status    (status),
    .valid     (valid),
    .out_char  (out_char),
    .last      (last)
  );

  // A character only follows a command issued while busy
  a_valid_from_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy))
    else $error("character strobe without an active transaction");

  // The load cycle emits nothing
  a_no_char_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !valid)
    else $error("character strobe right after a transaction was taken");

  // The final character coincides with the sequencer returning to idle
  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (valid && last) |-> !busy)
    else $error("last character while the sequencer is still busy");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    last |-> valid)
    else $error("last flag without a character strobe");

endmodule

`default_nettype wire

/* tb/fpda_text_checker.sv */
// Checker for the formatter: mirrors the registers, predicts each character and compares.
`timescale 1ns / 1ps

module fpda_text_checker
  import fpda_pkg::*;
#(
  parameter int MAX_MIN_WIDTH = MAX_MIN_WIDTH_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  input  logic [DATA_W-1:0]       prdata,
  input  logic                    pready,
  input  logic                    start,
  input  logic                    busy,
  input  logic [INT_BITS-1:0]     int_part,
  input  logic [FRAC_IN_BITS-1:0] frac_part,
  input  logic                    valid,
  input  logic [CHAR_W-1:0]       out_char,
  input  logic                    last,
  output int                      errors,
  output int                      chars_pending,
  output int                      chars_checked
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  text_char_t pending_text[$];
  cfg_t       shadow;

  // Append the full text of one number to the queue of characters still to come.
  function automatic void render_decimal(input logic [INT_BITS-1:0] ival,
                                         input logic [FRAC_IN_BITS-1:0] fval);
    logic [CHAR_W-1:0] int_txt[$];
    logic [CHAR_W-1:0] frac_txt[$];
    logic [CHAR_W-1:0] txt[$];
    int unsigned       rest;
    int                width;
    int                fd;
    longint unsigned   scale;
    longint unsigned   scaled;
    rest = ival;
    do begin
      int_txt.push_front(CHAR_W'(CH_ZERO + rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    width = (shadow.min_width > MAX_MIN_WIDTH) ? MAX_MIN_WIDTH : int'(shadow.min_width);
    for (int n = int_txt.size(); n < width; n++) begin
      txt.push_back(shadow.pad_with_zero ? CH_ZERO : CH_SPACE);
    end
    txt = {txt, int_txt};
    fd = (shadow.frac_digits > FRAC_DIGITS_MAX) ? FRAC_DIGITS_MAX : int'(shadow.frac_digits);
    if (fd != 0) begin
      scale = 1;
      repeat (fd) scale = scale * 10;
      // drop fraction bits above FRAC_BITS, then truncate, never round
      scaled = ((longint'(fval) & ((64'd1 << FRAC_BITS) - 1)) * scale) >> FRAC_BITS;
      repeat (fd) begin
        frac_txt.push_front(CHAR_W'(CH_ZERO + scaled % 10));
        scaled = scaled / 10;
      end
      txt.push_back(CH_POINT);
      txt = {txt, frac_txt};
    end
    foreach (txt[k]) pending_text.push_back('{ch: txt[k], last: (k == txt.size() - 1)});
  endfunction

  always @(posedge clk) begin
    text_char_t head;
    int         n_bad;
    n_bad = 0;
    if (rst) begin
      shadow <= '0;
      pending_text.delete();
      chars_pending <= 0;
    end else begin
      // Compare before predicting: a character this cycle belongs to an earlier number.
      if (valid) begin
        if (pending_text.size() == 0) begin
          $error("out_char: no character expected, got %h", out_char);
          n_bad++;
        end else begin
          head = pending_text.pop_front();
          if (out_char !== head.ch) begin
            $error("out_char: expected %h, got %h", head.ch, out_char);
            n_bad++;
          end
          if (last !== head.last) begin
            $error("last: expected %b, got %b", head.last, last);
            n_bad++;
          end
          chars_checked <= chars_checked + 1;
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_MIN_WIDTH:     shadow.min_width     <= pwdata[MIN_WIDTH_BITS-1:0];
            REG_PAD_WITH_ZERO: shadow.pad_with_zero <= pwdata[0];
            REG_FRAC_DIGITS:   shadow.frac_digits   <= pwdata[FRAC_DIG_BITS-1:0];
            default: ;
          endcase
        end else begin
          case (paddr[3:2])
            REG_MIN_WIDTH:
              if (prdata !== DATA_W'(shadow.min_width)) begin
                $error("min_width: expected %h, got %h", DATA_W'(shadow.min_width), prdata);
                n_bad++;
              end
            REG_PAD_WITH_ZERO:
              if (prdata !== DATA_W'(shadow.pad_with_zero)) begin
                $error("pad_with_zero: expected %h, got %h",
                       DATA_W'(shadow.pad_with_zero), prdata);
                n_bad++;
              end
            REG_FRAC_DIGITS:
              if (prdata !== DATA_W'(shadow.frac_digits)) begin
                $error("frac_digits: expected %h, got %h",
                       DATA_W'(shadow.frac_digits), prdata);
                n_bad++;
              end
            default: ;
          endcase
        end
      end
      if (start && !busy) render_decimal(int_part, frac_part);
      chars_pending <= pending_text.size();
    end
    errors <= errors + n_bad;
  end

endmodule

/* tb/fixed_point_to_decimal_ascii_test.sv */
// Top of the formatter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module fixed_point_to_decimal_ascii_test;
  import fpda_pkg::*;

  // Register slot past the last real register; writes to it must be dropped.
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    start = 1'b0;
  logic                    busy;
  logic [INT_BITS-1:0]     int_part = '0;
  logic [FRAC_IN_BITS-1:0] frac_part = '0;
  logic                    valid;
  logic [CHAR_W-1:0]       out_char;
  logic                    last;

  int errors;
  int chars_pending;
  int chars_checked;
  int numbers_sent = 0;
  int settings_used = 1;

  // Directed numbers: field extremes, several digit count edges, fraction truncation edges
  // (6553 shows as .0999, 6554 just crosses to .1000), a lone zero and an all-zero fraction.
  logic [INT_BITS-1:0]     dir_int[6]  = '{31'd0, 31'h7FFF_FFFF, 31'd1,
                                           31'd1_000_000_000, 31'd9, 31'd99_999};
  logic [FRAC_IN_BITS-1:0] dir_frac[6] = '{16'd0, 16'hFFFF, 16'd1,
                                           16'h8000, 16'd6554, 16'd6553};

  always #4 clk = ~clk;

  fixed_point_to_decimal_ascii dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .int_part, .frac_part, .valid, .out_char, .last
  );

  fpda_text_checker checker_i (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .int_part, .frac_part, .valid, .out_char, .last,
    .errors, .chars_pending, .chars_checked
  );

  // All tasks start just after a rising edge and return just after one.
  // A bus transaction is setup, access, then an idle step, so that the next one
  // never assigns psel in the same time step as this one lowers it.
  task automatic bus_access(input logic is_write, input logic [1:0] idx,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drain every outstanding character, then let the block fall idle before any
  // register traffic. The first edge lets the checker's count of the last
  // transaction show up.
  task automatic drain;
    do @(posedge clk); while (chars_pending != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers with junk above each field, now and then poke the spare slot,
  // then read everything back.
  task automatic apply_settings(input int mw, input int pad, input int fd);
    bus_access(1'b1, REG_MIN_WIDTH, ($urandom & 32'hFFFF_FFE0) | DATA_W'(mw));
    bus_access(1'b1, REG_PAD_WITH_ZERO, ($urandom & 32'hFFFF_FFFE) | DATA_W'(pad));
    bus_access(1'b1, REG_FRAC_DIGITS, ($urandom & 32'hFFFF_FFF8) | DATA_W'(fd));
    if ($urandom_range(0, 1)) bus_access(1'b1, REG_SPARE, $urandom);
    bus_access(1'b0, REG_MIN_WIDTH, '0);
    bus_access(1'b0, REG_PAD_WITH_ZERO, '0);
    bus_access(1'b0, REG_FRAC_DIGITS, '0);
    settings_used++;
  endtask

  // Mostly numbers of a random digit count, so that short and long integers both
  // show up often, plus zero, the maximum and raw random bits.
  function automatic logic [INT_BITS-1:0] pick_integer;
    longint lo;
    longint hi;
    int     nd;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return INT_BITS'($urandom);
      default: begin
        nd = $urandom_range(1, 10);
        lo = 1;
        repeat (nd - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (nd == 1) lo = 0;
        if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
        return INT_BITS'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
      end
    endcase
  endfunction

  // Fractions near the point where a four-digit truncation steps up are the
  // interesting ones; hit them on purpose, at the step or one unit below it.
  function automatic logic [FRAC_IN_BITS-1:0] pick_fraction;
    int unsigned k;
    int unsigned f;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    begin
        k = $urandom_range(0, 9999);
        f = (k * 65536 + 9999) / 10000;
        if (f > 0 && $urandom_range(0, 1)) f = f - 1;
        return FRAC_IN_BITS'(f);
      end
      default: return FRAC_IN_BITS'($urandom);
    endcase
  endfunction

  // Send a batch of numbers in bursts. Start stays high across a burst; between
  // bursts it drops for a random gap, or now and then until the block has
  // emitted everything it owes.
  task automatic send_batch(input bit directed, input int count);
    int burst_left;
    burst_left = $urandom_range(1, 8);
    for (int i = 0; i < count; i++) begin
      start     <= 1'b1;
      int_part  <= directed ? dir_int[i % 6]  : pick_integer();
      frac_part <= directed ? dir_frac[i % 6] : pick_fraction();
      do @(posedge clk); while (busy);
      numbers_sent++;
      if (i == count - 1) break;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        start <= 1'b0;
        if ($urandom_range(0, 9) == 0) begin
          do @(posedge clk); while (chars_pending != 0);
        end else begin
          repeat ($urandom_range(1, 60)) @(posedge clk);
        end
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    int mw;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values read back as zero, then the directed numbers under each of
    // several settings: defaults, everything saturated, the widest legal, narrow.
    bus_access(1'b0, REG_MIN_WIDTH, '0);
    bus_access(1'b0, REG_PAD_WITH_ZERO, '0);
    bus_access(1'b0, REG_FRAC_DIGITS, '0);
    send_batch(1'b1, 6);
    drain();
    apply_settings(31, 1, 7);
    send_batch(1'b1, 6);
    drain();
    apply_settings(16, 0, 4);
    send_batch(1'b1, 6);
    drain();
    apply_settings(2, 1, 1);
    send_batch(1'b1, 6);

    // Random phases: a fresh setting each time, saturating values included.
    for (int phase = 0; phase < 9; phase++) begin
      drain();
      case ($urandom_range(0, 5))
        0:       mw = 0;
        1:       mw = MAX_MIN_WIDTH_DEF;
        2:       mw = $urandom_range(MAX_MIN_WIDTH_DEF + 1, 31);
        default: mw = $urandom_range(1, MAX_MIN_WIDTH_DEF - 1);
      endcase
      apply_settings(mw, $urandom_range(0, 1), $urandom_range(0, 7));
      send_batch(1'b0, 22);
    end

    // Hold until nothing is owed, then watch for stray characters a while longer.
    do @(posedge clk); while (chars_pending != 0);
    repeat (80) @(posedge clk);

    $display("Covered %0d numbers under %0d register settings, %0d characters compared.",
             numbers_sent, settings_used, chars_checked);
    if (errors == 0 && chars_pending == 0) begin
      $display("fixed_point_to_decimal_ascii test passed");
    end else begin
      $display("fixed_point_to_decimal_ascii test failed");
    end
    $finish;
  end

  // Far beyond the slowest legal run of all 222 numbers.
  initial begin
    #2_000_000;
    $display("fixed_point_to_decimal_ascii test failed");
    $finish;
  end

endmodule
